### src/neighbor_table_stats_defines.svh
// assertion macros shared by the checker
`ifndef NEIGHBOR_TABLE_STATS_DEFINES_SVH
`define NEIGHBOR_TABLE_STATS_DEFINES_SVH

// same-cycle implication
`define NTS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define NTS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### src/nts_pkg.sv
package nts_pkg;

	localparam int IN_DATA_W  = 64;
	localparam int OUT_DATA_W = 112;

	typedef enum logic {
		OP_UPDATE = 1'b0,
		OP_REMOVE = 1'b1
	} nts_op_t;

	typedef enum logic [1:0] {
		ST_UPDATED  = 2'd0,
		ST_ADDED    = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOTFOUND = 2'd3
	} nts_status_t;

	// one table entry
	typedef struct packed {
		logic [31:0] id;
		logic [7:0]  ctr;
		logic [31:0] missed;
		logic [31:0] pkts;
		logic [31:0] bytes;
		logic [11:0] rssi;
	} nts_rec_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic commit;
	} nts_cmd_t;

	typedef struct packed {
		logic done;
		logic out_busy;
	} nts_sts_t;

endpackage

### src/nts_ctrl.sv
module nts_ctrl
	import nts_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_axis_tvalid,
	output logic     s_axis_tready,
	input  nts_sts_t sts,
	output nts_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_UPD
	} state_t;

	state_t state_q;
	logic   ready_q;

	assign s_axis_tready = ready_q;

	always_comb begin
		cmd        = '0;
		cmd.load   = s_axis_tvalid && ready_q;
		cmd.scan   = (state_q == S_SCAN);
		cmd.commit = (state_q == S_UPD) && !sts.out_busy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ready_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					ready_q <= 1'b1;
					if (s_axis_tvalid && ready_q) begin
						ready_q <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (sts.done) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					if (!sts.out_busy) begin
						ready_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
					ready_q <= 1'b0;
				end
			endcase
		end
	end

endmodule

### src/nts_datapath.sv
module nts_datapath
	import nts_pkg::*;
#(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  nts_cmd_t              cmd,
	output nts_sts_t              sts,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	input  logic                  s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	output logic [1:0]            m_axis_tuser
);

	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam logic [IW-1:0] LAST = IW'(TABLE_ENTRIES - 1);

	nts_rec_t               mem_q [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] valid_q;

	logic          op_q;
	logic [31:0]   id_q;
	logic [7:0]    ctr_q;
	logic [7:0]    len_q;
	logic [11:0]   smp_q;

	logic [IW-1:0] idx_q;
	logic          issued_all_q;
	logic [IW-1:0] free_q;
	logic          free_vld_q;
	nts_rec_t      rd_rec_s1;
	logic [IW-1:0] rd_idx_s1;
	logic          rd_vld_s1;
	logic          hit_q;
	logic [IW-1:0] hit_idx_q;

	logic          out_valid_q;
	logic [1:0]    out_status_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	logic          match_w;
	logic          last_w;
	logic          issue;

	nts_rec_t      base;
	nts_rec_t      upd;
	logic          ok_upd;
	logic          set_valid;
	logic          clr_valid;
	logic [IW-1:0] slot;
	nts_status_t   res_status;
	logic [7:0]    diff;
	logic          diff_pos;
	logic [16:0]   rssi_sum;
	logic [IW+3:0] slot_ext;
	nts_rec_t      res_rec;

	assign match_w = rd_vld_s1 && valid_q[rd_idx_s1] && (rd_rec_s1.id == id_q);
	assign last_w  = rd_vld_s1 && (rd_idx_s1 == LAST);
	assign issue   = cmd.scan && !match_w && !issued_all_q;

	assign sts.done     = match_w || last_w;
	assign sts.out_busy = out_valid_q && !m_axis_tready;

	always_comb begin
		base       = '0;
		ok_upd     = 1'b0;
		set_valid  = 1'b0;
		clr_valid  = 1'b0;
		slot       = '0;
		res_status = ST_UPDATED;
		if (op_q == OP_REMOVE) begin
			if (hit_q) begin
				clr_valid = 1'b1;
				slot      = hit_idx_q;
			end else begin
				res_status = ST_NOTFOUND;
			end
		end else if (hit_q) begin
			base   = rd_rec_s1;
			slot   = hit_idx_q;
			ok_upd = 1'b1;
		end else if (free_vld_q) begin
			base.id    = id_q;
			slot       = free_q;
			ok_upd     = 1'b1;
			set_valid  = 1'b1;
			res_status = ST_ADDED;
		end else begin
			res_status = ST_FULL;
		end

		diff     = ctr_q - base.ctr;
		diff_pos = (diff != 8'd0) && !diff[7];
		upd      = base;
		if (diff_pos) begin
			upd.missed = base.missed + {24'd0, diff - 8'd1};
			upd.ctr    = ctr_q;
		end
		upd.pkts  = base.pkts + 32'd1;
		upd.bytes = base.bytes + {24'd0, len_q};
		// 15*avg + sample, then floor divide by 16
		rssi_sum  = {base.rssi[11], base.rssi, 4'd0}
			- {{5{base.rssi[11]}}, base.rssi}
			+ {{5{smp_q[11]}}, smp_q};
		upd.rssi  = rssi_sum[15:4];

		res_rec  = ok_upd ? upd : '0;
		slot_ext = {4'd0, slot};
	end

	// table storage and input capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= s_axis_tuser;
			id_q  <= s_axis_tdata[31:0];
			ctr_q <= s_axis_tdata[39:32];
			len_q <= s_axis_tdata[47:40];
			smp_q <= s_axis_tdata[59:48];
		end
		if (issue) begin
			rd_rec_s1 <= mem_q[idx_q];
			rd_idx_s1 <= idx_q;
		end
		if (issue && !valid_q[idx_q] && !free_vld_q) begin
			free_q <= idx_q;
		end
		if (cmd.scan && sts.done) begin
			hit_idx_q <= rd_idx_s1;
		end
		if (cmd.commit && ok_upd) begin
			mem_q[slot] <= upd;
		end
		if (cmd.commit) begin
			out_status_q <= res_status;
			out_data_q   <= {res_rec.rssi, res_rec.bytes, res_rec.pkts, res_rec.missed,
				slot_ext[3:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			idx_q        <= '0;
			issued_all_q <= 1'b0;
			free_vld_q   <= 1'b0;
			rd_vld_s1    <= 1'b0;
			hit_q        <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (cmd.load) begin
				idx_q        <= '0;
				issued_all_q <= 1'b0;
				free_vld_q   <= 1'b0;
				rd_vld_s1    <= 1'b0;
			end else if (issue) begin
				if (idx_q == LAST) begin
					issued_all_q <= 1'b1;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
				if (!valid_q[idx_q]) begin
					free_vld_q <= 1'b1;
				end
			end
			if (cmd.scan && sts.done) begin
				hit_q <= match_w;
			end
			if (cmd.commit && set_valid) begin
				valid_q[slot] <= 1'b1;
			end
			if (cmd.commit && clr_valid) begin
				valid_q[slot] <= 1'b0;
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_status_q;

endmodule

### src/neighbor_table_stats.sv
// Neighbor table with per-neighbor receive statistics. One item at a time is
// handled: after acceptance the single table read port walks the slots one per
// cycle from slot 0, the registered read data is compared, and the walk stops at
// the first valid slot whose id matches; then the entry is updated and the
// result register loaded. A match in slot 0 ends the walk soonest; with no match
// all TABLE_ENTRIES slots are read; the walk sets how long an item takes.
// A waiting result does not block the next item, which is accepted and scanned
// while the result register is held; only the update waits for it to drain.
// Slot valid bits clear at reset, so no table clearing pass is needed.
module neighbor_table_stats
	import nts_pkg::*;
#(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// neighbor_id, packet_counter, packet_length, rssi_sample, zero pad
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// op
	input  logic                  s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// slot_index, missed_total, packets_total, bytes_total, rssi_average
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	// status
	output logic [1:0]            m_axis_tuser
);

	nts_cmd_t cmd;
	nts_sts_t sts;

	nts_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.sts           (sts),
		.cmd           (cmd)
	);

	nts_datapath #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

### src/neighbor_table_stats_checker.sv
`include "neighbor_table_stats_defines.svh"

module neighbor_table_stats_checker
	import nts_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tvalid,
	input logic                  s_axis_tready,
	input logic [IN_DATA_W-1:0]  s_axis_tdata,
	input logic                  s_axis_tuser,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata,
	input logic [1:0]            m_axis_tuser
);

	`NTS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

	`NTS_ASSERT_NEXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second item taken during scan")

	`NTS_ASSERT_NOW(a_fail_zero, m_axis_tvalid && (m_axis_tuser == ST_FULL || m_axis_tuser == ST_NOTFOUND), m_axis_tdata == '0, "failure result not zero")

	`NTS_ASSERT_NOW(a_new_count, m_axis_tvalid && m_axis_tuser == ST_ADDED, m_axis_tdata[67:36] == 32'd1 && m_axis_tdata[99:76] == 24'd0, "new neighbor counts wrong")

endmodule

bind neighbor_table_stats neighbor_table_stats_checker u_chk (.*);

### verif/neighbor_table_stats_tb.sv
module neighbor_table_stats_tb;
	import nts_pkg::*;

	localparam int SLOTS        = 16;
	localparam int RANDOM_ITEMS = 2000;
	localparam int POOL_SIZE    = 24;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		nts_status_t status;
		logic [3:0]  slot;
		logic [31:0] missed;
		logic [31:0] pkts;
		logic [31:0] bytes;
		logic [11:0] rssi;
	} nts_result_t;

	typedef struct {
		nts_op_t     op;
		logic [31:0] id;
		logic [7:0]  ctr;
		logic [7:0]  len;
		logic [11:0] rssi;
		bit          typed;
		nts_result_t result;
	} stim_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic                  s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [1:0]            m_axis_tuser;

	// predicted table contents
	bit          tbl_valid [SLOTS];
	logic [31:0] tbl_id    [SLOTS];
	logic [7:0]  tbl_ctr   [SLOTS];
	logic [31:0] tbl_missed[SLOTS];
	logic [31:0] tbl_pkts  [SLOTS];
	logic [31:0] tbl_bytes [SLOTS];
	logic [11:0] tbl_rssi  [SLOTS];

	nts_result_t pending_results[$];
	stim_row_t   directed_rows[$];
	logic [31:0] id_pool[POOL_SIZE];
	logic [7:0]  pool_ctr[POOL_SIZE];

	int  failures;
	int  cycles;
	int  results_seen;
	int  added_cnt, updated_cnt, removed_cnt, full_cnt, notfound_cnt;
	bit  quiet;
	bit  sender_idles;

	neighbor_table_stats #(
		.TABLE_ENTRIES(SLOTS)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic nts_result_t predict_neighbor_update(input nts_op_t op,
		input logic [31:0] id, input logic [7:0] ctr, input logic [7:0] len,
		input logic [11:0] sample);
		nts_result_t r;
		int          hit;
		int          slot;
		logic [7:0]  d;
		int          sum;
		r    = '0;
		hit  = -1;
		slot = -1;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (tbl_valid[i] && tbl_id[i] == id)
				hit = i;
			if (!tbl_valid[i])
				slot = i;
		end
		if (op == OP_REMOVE) begin
			if (hit < 0) begin
				r.status = ST_NOTFOUND;
			end else begin
				tbl_valid[hit] = 1'b0;
				r.status = ST_UPDATED;
				r.slot   = 4'(hit);
			end
			return r;
		end
		if (hit < 0) begin
			if (slot < 0) begin
				r.status = ST_FULL;
				return r;
			end
			tbl_valid[slot]  = 1'b1;
			tbl_id[slot]     = id;
			tbl_ctr[slot]    = '0;
			tbl_missed[slot] = '0;
			tbl_pkts[slot]   = '0;
			tbl_bytes[slot]  = '0;
			tbl_rssi[slot]   = '0;
			r.status = ST_ADDED;
		end else begin
			slot = hit;
			r.status = ST_UPDATED;
		end
		d = ctr - tbl_ctr[slot];
		if (d >= 8'd1 && d <= 8'd127) begin
			tbl_missed[slot] = tbl_missed[slot] + 32'(d) - 32'd1;
			tbl_ctr[slot]    = ctr;
		end
		tbl_pkts[slot]  = tbl_pkts[slot] + 32'd1;
		tbl_bytes[slot] = tbl_bytes[slot] + 32'(len);
		sum = 15 * int'($signed(tbl_rssi[slot])) + int'($signed(sample));
		tbl_rssi[slot] = 12'(sum >>> 4);
		r.slot   = 4'(slot);
		r.missed = tbl_missed[slot];
		r.pkts   = tbl_pkts[slot];
		r.bytes  = tbl_bytes[slot];
		r.rssi   = tbl_rssi[slot];
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] exp_v,
		input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s expected %0d actual %0d", name, exp_v, act_v);
			failures++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				$error("result item with no expectation waiting");
				failures++;
			end else begin
				nts_result_t e;
				e = pending_results.pop_front();
				check_field("status", 32'(e.status), 32'(m_axis_tuser));
				check_field("slot_index", 32'(e.slot), 32'(m_axis_tdata[3:0]));
				check_field("missed_total", e.missed, m_axis_tdata[35:4]);
				check_field("packets_total", e.pkts, m_axis_tdata[67:36]);
				check_field("bytes_total", e.bytes, m_axis_tdata[99:68]);
				check_field("rssi_average", 32'(e.rssi), 32'(m_axis_tdata[111:100]));
				results_seen++;
			end
		end
	end

	always @(negedge clk) begin
		m_axis_tready <= quiet || ($urandom_range(99) >= 35);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic send_item(input nts_op_t op, input logic [31:0] id,
		input logic [7:0] ctr, input logic [7:0] len, input logic [11:0] rssi,
		input bit typed, input nts_result_t typed_result);
		nts_result_t p;
		@(negedge clk);
		while (sender_idles && !quiet && $urandom_range(99) < 35) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {4'b0, rssi, len, ctr, id};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		p = predict_neighbor_update(op, id, ctr, len, rssi);
		case (p.status)
			ST_ADDED:    added_cnt++;
			ST_FULL:     full_cnt++;
			ST_NOTFOUND: notfound_cnt++;
			default: begin
				if (op == OP_REMOVE)
					removed_cnt++;
				else
					updated_cnt++;
			end
		endcase
		pending_results.push_back(typed ? typed_result : p);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic add_row(input nts_op_t op, input logic [31:0] id,
		input logic [7:0] ctr, input logic [7:0] len, input logic [11:0] rssi,
		input bit typed, input nts_status_t st, input logic [3:0] slot,
		input logic [31:0] missed, input logic [31:0] pkts, input logic [31:0] bytes,
		input logic [11:0] avg);
		stim_row_t row;
		row.op     = op;
		row.id     = id;
		row.ctr    = ctr;
		row.len    = len;
		row.rssi   = rssi;
		row.typed  = typed;
		row.result = '{st, slot, missed, pkts, bytes, avg};
		directed_rows.push_back(row);
	endtask

	initial begin
		int          r;
		int          k;
		nts_op_t     op;
		logic [31:0] id;
		logic [7:0]  ctr;
		logic [7:0]  len;
		logic [11:0] rssi;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = OP_UPDATE;
		m_axis_tready = 1'b0;
		quiet         = 1'b0;
		sender_idles  = 1'b1;
		failures      = 0;
		cycles        = 0;
		results_seen  = 0;
		added_cnt     = 0;
		updated_cnt   = 0;
		removed_cnt   = 0;
		full_cnt      = 0;
		notfound_cnt  = 0;
		for (int i = 0; i < SLOTS; i++)
			tbl_valid[i] = 1'b0;

		// extremes, then fill the table, overflow, remove and re-add
		add_row(OP_UPDATE, 32'h0, 8'd0, 8'd0, 12'h000, 1, ST_ADDED, 4'd0, 0, 1, 0, 12'h000);
		add_row(OP_UPDATE, 32'hFFFF_FFFF, 8'd255, 8'd255, 12'h800, 1,
			ST_ADDED, 4'd1, 0, 1, 255, 12'hF80);
		add_row(OP_REMOVE, 32'h5, 8'd0, 8'd0, 12'h000, 1, ST_NOTFOUND, 4'd0, 0, 0, 0, 12'h000);
		add_row(OP_UPDATE, 32'h1, 8'd127, 8'd1, 12'h7FF, 1,
			ST_ADDED, 4'd2, 126, 1, 1, 12'h07F);
		add_row(OP_UPDATE, 32'h1, 8'd128, 8'd200, 12'h7FF, 0, ST_UPDATED, 0, 0, 0, 0, 0);
		add_row(OP_UPDATE, 32'hFFFF_FFFF, 8'd0, 8'd0, 12'h7FF, 0, ST_UPDATED, 0, 0, 0, 0, 0);
		add_row(OP_REMOVE, 32'h0, 8'd9, 8'd9, 12'h123, 1, ST_UPDATED, 4'd0, 0, 0, 0, 12'h000);
		for (int i = 0; i < 14; i++)
			add_row(OP_UPDATE, 32'h100 + i, 8'(i * 17), 8'(i * 13), 12'(i * 300), 0,
				ST_UPDATED, 0, 0, 0, 0, 0);
		add_row(OP_UPDATE, 32'hABCD_1234, 8'd1, 8'd1, 12'h001, 1,
			ST_FULL, 4'd0, 0, 0, 0, 12'h000);
		add_row(OP_REMOVE, 32'h1, 8'd0, 8'd0, 12'h000, 1, ST_UPDATED, 4'd2, 0, 0, 0, 12'h000);
		add_row(OP_REMOVE, 32'h1, 8'd0, 8'd0, 12'h000, 1, ST_NOTFOUND, 4'd0, 0, 0, 0, 12'h000);
		add_row(OP_UPDATE, 32'hABCD_1234, 8'd200, 8'd77, 12'hC00, 0, ST_UPDATED, 0, 0, 0, 0, 0);

		id_pool[0] = 32'hFFFF_FFFF;
		for (int i = 0; i < 14; i++)
			id_pool[1 + i] = 32'h100 + i;
		id_pool[15] = 32'hABCD_1234;
		for (int i = 16; i < POOL_SIZE; i++)
			id_pool[i] = $urandom;
		for (int i = 0; i < POOL_SIZE; i++)
			pool_ctr[i] = 8'($urandom);

		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i])
			send_item(directed_rows[i].op, directed_rows[i].id, directed_rows[i].ctr,
				directed_rows[i].len, directed_rows[i].rssi, directed_rows[i].typed,
				directed_rows[i].result);
		wait_drained();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			quiet = (n >= 800 && n < 1100);
			if (n == 1000)
				wait_drained();
			r   = $urandom_range(99);
			k   = $urandom_range(POOL_SIZE - 1);
			op  = OP_UPDATE;
			id  = id_pool[k];
			ctr = 8'($urandom);
			len = 8'($urandom);
			rssi = 12'($urandom);
			if (r < 12) begin
				op = OP_REMOVE;
			end else if (r < 15) begin
				op = OP_REMOVE;
				id = $urandom;
			end else if (r < 20) begin
				id = $urandom;
			end else if (r < 90) begin
				pool_ctr[k] = pool_ctr[k] + 8'($urandom_range(1, 4));
				ctr = pool_ctr[k];
				if ($urandom_range(1))
					rssi = 12'($signed(12'hE00) + $signed(12'($urandom_range(255))));
			end
			send_item(op, id, ctr, len, rssi, 0, '0);
		end
		quiet = 1'b0;
		@(negedge clk);
		s_axis_tvalid <= 1'b0;

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d results: %0d added, %0d updated, %0d removed",
			results_seen, added_cnt, updated_cnt, removed_cnt);
		$display("table full %0d times, remove of unknown id %0d times", full_cnt,
			notfound_cnt);
		if (failures == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
